/* src/stsfu_pkg.sv */
// Package with the sizes, register map, reset values and op codes of the factor update unit.
`default_nettype none
package stsfu_pkg;
   localparam int MODES         = 3;
   localparam int ROWS_PER_MODE = 1024;
   localparam int RANK_MAX      = 8;
   localparam int KERNEL_MAX    = 4;

   localparam int MODE_W   = 2;
   localparam int ROW_W    = 10;
   localparam int COL_W    = 3;
   localparam int KCOL_W   = 2;
   localparam int FADDR_W  = MODE_W + ROW_W + COL_W;
   localparam int CADDR_W  = MODE_W + COL_W + KCOL_W;
   localparam int FACTOR_DEPTH = MODES * ROWS_PER_MODE * RANK_MAX;
   localparam int CORE_DEPTH   = MODES * RANK_MAX * KERNEL_MAX;
   localparam int PADDR_W  = 5;

   localparam logic [2:0] OP_LOAD_FACTOR = 3'd0;
   localparam logic [2:0] OP_LOAD_CORE   = 3'd1;
   localparam logic [2:0] OP_TRAIN       = 3'd2;
   localparam logic [2:0] OP_PREDICT     = 3'd3;
   localparam logic [2:0] OP_READ_FACTOR = 3'd4;

   localparam logic [2:0] REG_LEARN_RATE = 3'd0;
   localparam logic [2:0] REG_REG_WEIGHT = 3'd1;
   localparam logic [2:0] REG_MODES      = 3'd2;
   localparam logic [2:0] REG_RANK_0     = 3'd3;
   localparam logic [2:0] REG_RANK_1     = 3'd4;
   localparam logic [2:0] REG_RANK_2     = 3'd5;
   localparam logic [2:0] REG_KERNEL     = 3'd6;

   localparam logic [23:0] LEARN_RATE_RESET = 24'd33554;
   localparam logic [23:0] REG_WEIGHT_RESET = 24'd838861;
   localparam logic [1:0]  MODES_RESET      = 2'd3;
   localparam logic [3:0]  RANK_RESET       = 4'd8;
   localparam logic [2:0]  KERNEL_RESET     = 3'd4;
endpackage
`default_nettype wire

/* src/stsfu_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module stsfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* src/sparse_tucker_sgd_factor_update_unit.sv */
// Top level of the sparse Tucker SGD factor update unit with its sequencer and shared multiplier.
//
//  channel  direction  handshake            contents
//  req_     in         req_valid/req_ready  op, mode, row_0..2, col, kernel_col, value
//  rsp_     out        rsp_valid/rsp_ready  prediction, residual, read_data
//  csr      in/out     psel/penable/pready  seven configuration registers
//
// Loads and unknown ops go straight to the finish state, and a factor read passes a capture
// state first. Predict fetches the rows of the active modes, forms the core products and the
// prediction; train then adds the gradient and the factor updates. The pace is set by the single
// shared multiplier and the one read port of each memory. A new transaction is taken only in the
// idle state; a finished result waits in the output register while the next one is accepted.
// Reset is synchronous and clears the control state and the configuration registers; the memories hold no reset.
`default_nettype none
module sparse_tucker_sgd_factor_update_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [2:0]                        req_op,
   input  wire logic [stsfu_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [stsfu_pkg::ROW_W-1:0]       req_row_0,
   input  wire logic [stsfu_pkg::ROW_W-1:0]       req_row_1,
   input  wire logic [stsfu_pkg::ROW_W-1:0]       req_row_2,
   input  wire logic [stsfu_pkg::COL_W-1:0]       req_col,
   input  wire logic [stsfu_pkg::KCOL_W-1:0]      req_kernel_col,
   input  wire logic signed [31:0]                req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [31:0]                     rsp_prediction,
   output logic signed [31:0]                     rsp_residual,
   output logic signed [31:0]                     rsp_read_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [stsfu_pkg::PADDR_W-1:0]     paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);
   typedef enum logic [4:0] {
      IDLE, RD_CAP, ROW_ISSUE, ROW_CAP, P_ISSUE, P_MUL, P_ACC, E_MUL, E_ACC, PRED,
      G_ISSUE, G_MUL, G_ACC, D_MUL, D_ACC, EV, U1_MUL, U1_ACC, U2_MUL, U2_ACC,
      U3_MUL, U3_ACC, FINISH
   } state_type;

   localparam logic signed [64:0] MAX65 = 65'sd2147483647;
   localparam logic signed [64:0] MIN65 = -65'sd2147483648;

   function automatic logic signed [31:0] sat65(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > MAX65) r = 32'sh7FFF_FFFF;
      else if (v < MIN65) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [3:0] clamp_rank(input logic [3:0] v);
      logic [3:0] r;
      if (v == 4'd0) r = 4'd1;
      else if (v > 4'(stsfu_pkg::RANK_MAX)) r = 4'(stsfu_pkg::RANK_MAX);
      else r = v;
      return r;
   endfunction

   state_type state_ff;

   logic [23:0] lr_ff, lambda_ff;
   logic [1:0]  modes_ff;
   logic [3:0]  rank_ff [stsfu_pkg::MODES];
   logic [2:0]  kernel_ff;

   logic [2:0]                    op_ff;
   logic                          mode_ok_ff;
   logic [stsfu_pkg::ROW_W-1:0]   rows_ff [stsfu_pkg::MODES];
   logic signed [31:0]            x_ff;

   logic [stsfu_pkg::MODE_W-1:0]  n_ff;
   logic [stsfu_pkg::COL_W-1:0]   j_ff;
   logic [stsfu_pkg::KCOL_W-1:0]  k_ff;
   logic [1:0]                    s_ff;

   logic signed [31:0] rowv_ff [stsfu_pkg::MODES][stsfu_pkg::RANK_MAX];
   logic signed [31:0] p_ff    [stsfu_pkg::MODES][stsfu_pkg::KERNEL_MAX];
   logic signed [31:0] exc_ff  [stsfu_pkg::MODES][stsfu_pkg::KERNEL_MAX];
   logic signed [31:0] gsv_ff  [stsfu_pkg::RANK_MAX];

   logic signed [39:0] acc_ff, eacc_ff;
   logic signed [63:0] prod_ff;
   logic               sh24_ff;
   logic signed [31:0] e_ff, t1_ff, t_ff;
   logic signed [31:0] pred_ff, resid_ff, rdata_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_pred_ff, rsp_resid_ff, rsp_rdata_ff;

   logic        accept;
   logic        finish_go;
   logic [1:0]  nm;
   logic [3:0]  rk_cur;
   logic [2:0]  nk;
   logic        last_j, last_k, last_n;

   logic signed [31:0] mul_a, mul_b;
   logic               mul_sh24;
   logic signed [64:0] rsum, rshift;
   logic signed [31:0] rnd;
   logic signed [39:0] acc_sum;
   logic signed [31:0] pred_c;
   logic signed [31:0] dot_sat;

   logic                          f_we, c_we;
   logic [stsfu_pkg::FADDR_W-1:0] f_waddr, f_raddr;
   logic [stsfu_pkg::CADDR_W-1:0] c_waddr, c_raddr;
   logic signed [31:0]            f_wdata;
   logic [31:0]                   f_rdata, c_rdata;

   assign pready         = 1'b1;
   assign req_ready      = (state_ff == IDLE);
   assign accept         = req_valid && (state_ff == IDLE);
   assign finish_go      = (state_ff == FINISH) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = rsp_pred_ff;
   assign rsp_residual   = rsp_resid_ff;
   assign rsp_read_data  = rsp_rdata_ff;

   assign nm     = (modes_ff < 2'd2) ? 2'd2 : modes_ff;
   assign nk     = (kernel_ff == 3'd0) ? 3'd1 :
                   ((kernel_ff > 3'(stsfu_pkg::KERNEL_MAX)) ? 3'(stsfu_pkg::KERNEL_MAX)
                                                            : kernel_ff);
   assign rk_cur = clamp_rank(rank_ff[n_ff]);
   assign last_j = ((4'(j_ff) + 4'd1) == rk_cur);
   assign last_k = ((3'(k_ff) + 3'd1) == nk);
   assign last_n = ((n_ff + 2'd1) == nm);

   always_comb begin
      mul_a    = rowv_ff[n_ff][j_ff];
      mul_b    = $signed(c_rdata);
      mul_sh24 = 1'b0;
      unique case (state_ff)
         G_MUL: begin
            mul_a = $signed(c_rdata);
            mul_b = exc_ff[n_ff][k_ff];
         end
         E_MUL: begin
            unique case (s_ff)
               2'd0: begin mul_a = p_ff[0][k_ff];   mul_b = p_ff[1][k_ff]; end
               2'd1: begin mul_a = p_ff[1][k_ff];   mul_b = p_ff[2][k_ff]; end
               2'd2: begin mul_a = p_ff[0][k_ff];   mul_b = p_ff[2][k_ff]; end
               default: begin mul_a = exc_ff[2][k_ff]; mul_b = p_ff[2][k_ff]; end
            endcase
         end
         D_MUL: begin
            mul_b = gsv_ff[j_ff];
         end
         U1_MUL: begin
            mul_a = e_ff;
            mul_b = gsv_ff[j_ff];
         end
         U2_MUL: begin
            mul_b    = $signed({8'd0, lambda_ff});
            mul_sh24 = 1'b1;
         end
         U3_MUL: begin
            mul_a    = t_ff;
            mul_b    = $signed({8'd0, lr_ff});
            mul_sh24 = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsum    = {prod_ff[63], prod_ff} + (sh24_ff ? 65'sd8388608 : 65'sd32768);
   assign rshift  = sh24_ff ? (rsum >>> 24) : (rsum >>> 16);
   assign rnd     = sat65(rshift);
   assign acc_sum = acc_ff + {{8{rnd[31]}}, rnd};
   assign pred_c  = sat65({{25{acc_ff[39]}}, acc_ff});
   assign dot_sat = sat65({{25{eacc_ff[39]}}, eacc_ff});

   always_comb begin
      f_we    = 1'b0;
      c_we    = 1'b0;
      f_waddr = {req_mode, req_row_0, req_col};
      f_wdata = req_value;
      c_waddr = {req_mode, req_col, req_kernel_col};
      f_raddr = {n_ff, rows_ff[n_ff], j_ff};
      c_raddr = {n_ff, j_ff, k_ff};
      if (state_ff == IDLE) begin
         f_raddr = {req_mode, req_row_0, req_col};
         f_we = accept && (req_op == stsfu_pkg::OP_LOAD_FACTOR) &&
                (req_mode < 2'(stsfu_pkg::MODES));
         c_we = accept && (req_op == stsfu_pkg::OP_LOAD_CORE) &&
                (req_mode < 2'(stsfu_pkg::MODES));
      end else if (state_ff == U3_ACC) begin
         f_we    = 1'b1;
         f_waddr = {n_ff, rows_ff[n_ff], j_ff};
         f_wdata = sat65({{33{rowv_ff[n_ff][j_ff][31]}}, rowv_ff[n_ff][j_ff]} -
                         {{33{rnd[31]}}, rnd});
      end
   end

   stsfu_ram #(.WIDTH(32), .DEPTH(stsfu_pkg::FACTOR_DEPTH)) factor_ram (
      .clock(clock), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
      .rd_addr(f_raddr), .rd_data(f_rdata)
   );

   stsfu_ram #(.WIDTH(32), .DEPTH(stsfu_pkg::CORE_DEPTH)) core_ram (
      .clock(clock), .wr_en(c_we), .wr_addr(c_waddr), .wr_data(req_value),
      .rd_addr(c_raddr), .rd_data(c_rdata)
   );

   always_comb begin
      unique case (paddr[4:2])
         stsfu_pkg::REG_LEARN_RATE: prdata = {8'd0, lr_ff};
         stsfu_pkg::REG_REG_WEIGHT: prdata = {8'd0, lambda_ff};
         stsfu_pkg::REG_MODES:      prdata = {30'd0, modes_ff};
         stsfu_pkg::REG_RANK_0:     prdata = {28'd0, rank_ff[0]};
         stsfu_pkg::REG_RANK_1:     prdata = {28'd0, rank_ff[1]};
         stsfu_pkg::REG_RANK_2:     prdata = {28'd0, rank_ff[2]};
         stsfu_pkg::REG_KERNEL:     prdata = {29'd0, kernel_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff      <= stsfu_pkg::LEARN_RATE_RESET;
         lambda_ff  <= stsfu_pkg::REG_WEIGHT_RESET;
         modes_ff   <= stsfu_pkg::MODES_RESET;
         rank_ff[0] <= stsfu_pkg::RANK_RESET;
         rank_ff[1] <= stsfu_pkg::RANK_RESET;
         rank_ff[2] <= stsfu_pkg::RANK_RESET;
         kernel_ff  <= stsfu_pkg::KERNEL_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[4:2])
            stsfu_pkg::REG_LEARN_RATE: lr_ff      <= pwdata[23:0];
            stsfu_pkg::REG_REG_WEIGHT: lambda_ff  <= pwdata[23:0];
            stsfu_pkg::REG_MODES:      modes_ff   <= pwdata[1:0];
            stsfu_pkg::REG_RANK_0:     rank_ff[0] <= pwdata[3:0];
            stsfu_pkg::REG_RANK_1:     rank_ff[1] <= pwdata[3:0];
            stsfu_pkg::REG_RANK_2:     rank_ff[2] <= pwdata[3:0];
            stsfu_pkg::REG_KERNEL:     kernel_ff  <= pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         prod_ff <= mul_a * mul_b;
         sh24_ff <= mul_sh24;
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  op_ff      <= req_op;
                  mode_ok_ff <= (req_mode < 2'(stsfu_pkg::MODES));
                  rows_ff[0] <= req_row_0;
                  rows_ff[1] <= req_row_1;
                  rows_ff[2] <= req_row_2;
                  x_ff       <= req_value;
                  pred_ff    <= '0;
                  resid_ff   <= '0;
                  rdata_ff   <= '0;
                  acc_ff     <= '0;
                  eacc_ff    <= '0;
                  n_ff       <= '0;
                  j_ff       <= '0;
                  k_ff       <= '0;
                  s_ff       <= '0;
                  unique case (req_op)
                     stsfu_pkg::OP_READ_FACTOR: state_ff <= RD_CAP;
                     stsfu_pkg::OP_TRAIN, stsfu_pkg::OP_PREDICT: state_ff <= ROW_ISSUE;
                     default: state_ff <= FINISH;
                  endcase
               end
            end
            RD_CAP: begin
               rdata_ff <= mode_ok_ff ? $signed(f_rdata) : 32'sd0;
               state_ff <= FINISH;
            end
            ROW_ISSUE: state_ff <= ROW_CAP;
            ROW_CAP: begin
               rowv_ff[n_ff][j_ff] <= $signed(f_rdata);
               state_ff <= ROW_ISSUE;
               if (last_j) begin
                  j_ff <= '0;
                  if (last_n) begin
                     n_ff     <= '0;
                     state_ff <= P_ISSUE;
                  end else begin
                     n_ff <= n_ff + 2'd1;
                  end
               end else begin
                  j_ff <= j_ff + 3'd1;
               end
            end
            P_ISSUE: state_ff <= P_MUL;
            P_MUL:   state_ff <= P_ACC;
            P_ACC: begin
               state_ff <= P_ISSUE;
               if (last_j) begin
                  p_ff[n_ff][k_ff] <= sat65({{25{acc_sum[39]}}, acc_sum});
                  acc_ff <= '0;
                  j_ff   <= '0;
                  if (last_k) begin
                     k_ff <= '0;
                     if (last_n) begin
                        n_ff     <= '0;
                        s_ff     <= '0;
                        state_ff <= E_MUL;
                     end else begin
                        n_ff <= n_ff + 2'd1;
                     end
                  end else begin
                     k_ff <= k_ff + 2'd1;
                  end
               end else begin
                  acc_ff <= acc_sum;
                  j_ff   <= j_ff + 3'd1;
               end
            end
            E_MUL: state_ff <= E_ACC;
            E_ACC: begin
               state_ff <= E_MUL;
               if (s_ff == 2'd0) begin
                  exc_ff[2][k_ff] <= rnd;
                  if (nm == 2'd2) begin
                     exc_ff[0][k_ff] <= p_ff[1][k_ff];
                     exc_ff[1][k_ff] <= p_ff[0][k_ff];
                     acc_ff <= acc_sum;
                  end
               end else if (s_ff == 2'd1) begin
                  exc_ff[0][k_ff] <= rnd;
               end else if (s_ff == 2'd2) begin
                  exc_ff[1][k_ff] <= rnd;
               end else begin
                  acc_ff <= acc_sum;
               end
               if ((nm == 2'd2) || (s_ff == 2'd3)) begin
                  s_ff <= '0;
                  if (last_k) begin
                     k_ff     <= '0;
                     state_ff <= PRED;
                  end else begin
                     k_ff <= k_ff + 2'd1;
                  end
               end else begin
                  s_ff <= s_ff + 2'd1;
               end
            end
            PRED: begin
               pred_ff  <= pred_c;
               resid_ff <= sat65({{33{x_ff[31]}}, x_ff} - {{33{pred_c[31]}}, pred_c});
               acc_ff   <= '0;
               state_ff <= (op_ff == stsfu_pkg::OP_TRAIN) ? G_ISSUE : FINISH;
            end
            G_ISSUE: state_ff <= G_MUL;
            G_MUL:   state_ff <= G_ACC;
            G_ACC: begin
               if (last_k) begin
                  gsv_ff[j_ff] <= sat65({{25{acc_sum[39]}}, acc_sum});
                  acc_ff   <= '0;
                  k_ff     <= '0;
                  state_ff <= D_MUL;
               end else begin
                  acc_ff   <= acc_sum;
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= G_ISSUE;
               end
            end
            D_MUL: state_ff <= D_ACC;
            D_ACC: begin
               eacc_ff <= eacc_ff + {{8{rnd[31]}}, rnd};
               if (last_j) begin
                  j_ff     <= '0;
                  state_ff <= EV;
               end else begin
                  j_ff     <= j_ff + 3'd1;
                  state_ff <= G_ISSUE;
               end
            end
            EV: begin
               e_ff <= sat65({{33{dot_sat[31]}}, dot_sat} - {{33{x_ff[31]}}, x_ff});
               eacc_ff  <= '0;
               state_ff <= U1_MUL;
            end
            U1_MUL: state_ff <= U1_ACC;
            U1_ACC: begin
               t1_ff    <= rnd;
               state_ff <= U2_MUL;
            end
            U2_MUL: state_ff <= U2_ACC;
            U2_ACC: begin
               t_ff     <= sat65({{33{t1_ff[31]}}, t1_ff} + {{33{rnd[31]}}, rnd});
               state_ff <= U3_MUL;
            end
            U3_MUL: state_ff <= U3_ACC;
            U3_ACC: begin
               state_ff <= U1_MUL;
               if (last_j) begin
                  j_ff <= '0;
                  if (last_n) begin
                     state_ff <= FINISH;
                  end else begin
                     n_ff     <= n_ff + 2'd1;
                     state_ff <= G_ISSUE;
                  end
               end else begin
                  j_ff <= j_ff + 3'd1;
               end
            end
            FINISH: begin
               if (finish_go) begin
                  rsp_pred_ff  <= pred_ff;
                  rsp_resid_ff <= resid_ff;
                  rsp_rdata_ff <= rdata_ff;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* verif/stsfu_checker.sv */
// Checker for the factor update unit: tracks its state, predicts each result and compares.
`timescale 1ns / 100ps
module stsfu_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_ready,
   input  wire logic [2:0]                         req_op,
   input  wire logic [stsfu_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [stsfu_pkg::ROW_W-1:0]        req_row_0,
   input  wire logic [stsfu_pkg::ROW_W-1:0]        req_row_1,
   input  wire logic [stsfu_pkg::ROW_W-1:0]        req_row_2,
   input  wire logic [stsfu_pkg::COL_W-1:0]        req_col,
   input  wire logic [stsfu_pkg::KCOL_W-1:0]       req_kernel_col,
   input  wire logic signed [31:0]                 req_value,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic signed [31:0]                 rsp_prediction,
   input  wire logic signed [31:0]                 rsp_residual,
   input  wire logic signed [31:0]                 rsp_read_data,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [stsfu_pkg::PADDR_W-1:0]      paddr,
   input  wire logic [31:0]                        pwdata,
   input  wire logic                               pready,
   output int                                      failures,
   output int                                      pending
);
   typedef struct {
      int prediction;
      int residual;
      int read_data;
   } factor_result_type;

   int                factor_mem [stsfu_pkg::FACTOR_DEPTH];
   int                core_mem [stsfu_pkg::CORE_DEPTH];
   logic [23:0]       lr_cfg;
   logic [23:0]       lambda_cfg;
   logic [1:0]        modes_cfg;
   logic [3:0]        rank_cfg [3];
   logic [2:0]        kernel_cfg;
   factor_result_type awaited_results [$];

   function automatic int sat32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic int mul_q16(input int a, input int b);
      longint pr;
      pr = longint'(a) * longint'(b);
      return sat32((pr + 64'sd32768) >>> 16);
   endfunction

   function automatic int mul_q24(input int a, input logic [23:0] w);
      longint pr;
      pr = longint'(a) * longint'({40'd0, w});
      return sat32((pr + 64'sd8388608) >>> 24);
   endfunction

   function automatic int faddr(input int m, input int row, input int j);
      return (m * stsfu_pkg::ROWS_PER_MODE + row) * stsfu_pkg::RANK_MAX + j;
   endfunction

   function automatic int caddr(input int m, input int j, input int k);
      return (m * stsfu_pkg::RANK_MAX + j) * stsfu_pkg::KERNEL_MAX + k;
   endfunction

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic apply_factor_update(output factor_result_type res);
      int     rows [3];
      int     rk [3];
      int     p [3][stsfu_pkg::KERNEL_MAX];
      int     gs [3][stsfu_pkg::RANK_MAX];
      int     nm, nk, prod, e, r, t, x, md, cl, kc;
      longint acc;
      res = '{0, 0, 0};
      x = req_value;
      md = int'(req_mode);
      cl = int'(req_col);
      kc = int'(req_kernel_col);
      rows[0] = int'(req_row_0);
      rows[1] = int'(req_row_1);
      rows[2] = int'(req_row_2);
      if (req_op == stsfu_pkg::OP_LOAD_FACTOR) begin
         if (md < stsfu_pkg::MODES) factor_mem[faddr(md, rows[0], cl)] = x;
      end else if (req_op == stsfu_pkg::OP_LOAD_CORE) begin
         if (md < stsfu_pkg::MODES) core_mem[caddr(md, cl, kc)] = x;
      end else if (req_op == stsfu_pkg::OP_READ_FACTOR) begin
         if (md < stsfu_pkg::MODES) res.read_data = factor_mem[faddr(md, rows[0], cl)];
      end else if (req_op == stsfu_pkg::OP_TRAIN || req_op == stsfu_pkg::OP_PREDICT) begin
         nm = clamp(int'(modes_cfg), 2, 3);
         nk = clamp(int'(kernel_cfg), 1, stsfu_pkg::KERNEL_MAX);
         for (int m = 0; m < 3; m++) rk[m] = clamp(int'(rank_cfg[m]), 1, stsfu_pkg::RANK_MAX);
         for (int n = 0; n < nm; n++)
            for (int k = 0; k < nk; k++) begin
               acc = 0;
               for (int j = 0; j < rk[n]; j++)
                  acc += mul_q16(factor_mem[faddr(n, rows[n], j)], core_mem[caddr(n, j, k)]);
               p[n][k] = sat32(acc);
            end
         acc = 0;
         for (int k = 0; k < nk; k++) begin
            prod = 65536;
            for (int n = 0; n < nm; n++) prod = mul_q16(prod, p[n][k]);
            acc += prod;
         end
         res.prediction = sat32(acc);
         res.residual = sat32(longint'(x) - longint'(res.prediction));
         if (req_op == stsfu_pkg::OP_TRAIN) begin
            for (int n = 0; n < nm; n++)
               for (int j = 0; j < rk[n]; j++) begin
                  acc = 0;
                  for (int k = 0; k < nk; k++) begin
                     prod = 65536;
                     for (int q = 0; q < nm; q++)
                        if (q != n) prod = mul_q16(prod, p[q][k]);
                     acc += mul_q16(core_mem[caddr(n, j, k)], prod);
                  end
                  gs[n][j] = sat32(acc);
               end
            for (int n = 0; n < nm; n++) begin
               acc = 0;
               for (int j = 0; j < rk[n]; j++)
                  acc += mul_q16(factor_mem[faddr(n, rows[n], j)], gs[n][j]);
               e = sat32(longint'(sat32(acc)) - longint'(x));
               for (int j = 0; j < rk[n]; j++) begin
                  r = factor_mem[faddr(n, rows[n], j)];
                  t = sat32(longint'(mul_q16(e, gs[n][j])) +
                            longint'(mul_q24(r, lambda_cfg)));
                  factor_mem[faddr(n, rows[n], j)] =
                     sat32(longint'(r) - longint'(mul_q24(t, lr_cfg)));
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      factor_result_type exp_res;
      factor_result_type new_res;
      if (reset) begin
         lr_cfg      <= stsfu_pkg::LEARN_RATE_RESET;
         lambda_cfg  <= stsfu_pkg::REG_WEIGHT_RESET;
         modes_cfg   <= stsfu_pkg::MODES_RESET;
         rank_cfg[0] <= stsfu_pkg::RANK_RESET;
         rank_cfg[1] <= stsfu_pkg::RANK_RESET;
         rank_cfg[2] <= stsfu_pkg::RANK_RESET;
         kernel_cfg  <= stsfu_pkg::KERNEL_RESET;
         awaited_results.delete();
         failures = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               stsfu_pkg::REG_LEARN_RATE: lr_cfg <= pwdata[23:0];
               stsfu_pkg::REG_REG_WEIGHT: lambda_cfg <= pwdata[23:0];
               stsfu_pkg::REG_MODES:      modes_cfg <= pwdata[1:0];
               stsfu_pkg::REG_RANK_0:     rank_cfg[0] <= pwdata[3:0];
               stsfu_pkg::REG_RANK_1:     rank_cfg[1] <= pwdata[3:0];
               stsfu_pkg::REG_RANK_2:     rank_cfg[2] <= pwdata[3:0];
               stsfu_pkg::REG_KERNEL:     kernel_cfg <= pwdata[2:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result transaction with no expectation waiting");
               failures++;
            end else begin
               exp_res = awaited_results.pop_front();
               if (rsp_prediction !== exp_res.prediction) begin
                  $error("prediction: expected %0d, got %0d", exp_res.prediction, rsp_prediction);
                  failures++;
               end
               if (rsp_residual !== exp_res.residual) begin
                  $error("residual: expected %0d, got %0d", exp_res.residual, rsp_residual);
                  failures++;
               end
               if (rsp_read_data !== exp_res.read_data) begin
                  $error("read_data: expected %0d, got %0d", exp_res.read_data, rsp_read_data);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_factor_update(new_res);
            awaited_results.push_back(new_res);
         end
      end
      pending = awaited_results.size();
   end
endmodule

/* verif/tb_sparse_tucker_sgd_factor_update_unit.sv */
// Testbench top for the factor update unit: clock, reset, stimulus, register setup and verdict.
`timescale 1ns / 100ps
module tb_sparse_tucker_sgd_factor_update_unit;
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam int         MODE_NONE       = 3;
   localparam int         CYCLE_LIMIT     = 3000000;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [2:0]                           req_op = '0;
   logic [stsfu_pkg::MODE_W-1:0]         req_mode = '0;
   logic [stsfu_pkg::ROW_W-1:0]          req_row_0 = '0;
   logic [stsfu_pkg::ROW_W-1:0]          req_row_1 = '0;
   logic [stsfu_pkg::ROW_W-1:0]          req_row_2 = '0;
   logic [stsfu_pkg::COL_W-1:0]          req_col = '0;
   logic [stsfu_pkg::KCOL_W-1:0]         req_kernel_col = '0;
   logic signed [31:0]                   req_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [31:0]                   rsp_prediction;
   logic signed [31:0]                   rsp_residual;
   logic signed [31:0]                   rsp_read_data;
   logic                                 psel = 1'b0;
   logic                                 penable = 1'b0;
   logic                                 pwrite = 1'b0;
   logic [stsfu_pkg::PADDR_W-1:0]        paddr = '0;
   logic [31:0]                          pwdata = '0;
   logic [31:0]                          prdata;
   logic                                 pready;
   int                                   failures;
   int                                   pending;
   int                                   cycles = 0;
   bit                                   idling = 1'b1;
   int                                   loaded_rows [3][$];

   sparse_tucker_sgd_factor_update_unit dut (.*);

   stsfu_checker result_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_sparse_tucker_sgd_factor_update_unit failed");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic int small_q16();
      return int'($urandom_range(0, 131072)) - 65536;
   endfunction

   function automatic int pick_row(input int m);
      return loaded_rows[m][$urandom_range(0, loaded_rows[m].size() - 1)];
   endfunction

   task automatic send_item(input logic [2:0] op, input int mode,
                            input int r0, input int r1, input int r2,
                            input int col, input int kcol, input int value);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_mode       <= mode[stsfu_pkg::MODE_W-1:0];
      req_row_0      <= r0[stsfu_pkg::ROW_W-1:0];
      req_row_1      <= r1[stsfu_pkg::ROW_W-1:0];
      req_row_2      <= r2[stsfu_pkg::ROW_W-1:0];
      req_col        <= col[stsfu_pkg::COL_W-1:0];
      req_kernel_col <= kcol[stsfu_pkg::KCOL_W-1:0];
      req_value      <= value;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic load_row(input int m, input int row);
      for (int j = 0; j < stsfu_pkg::RANK_MAX; j++)
         send_item(stsfu_pkg::OP_LOAD_FACTOR, m, row, $urandom, $urandom, j, $urandom,
                   small_q16() / 2);
      loaded_rows[m].push_back(row);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int lr, input int lambda, input int modes,
                            input int rk0, input int rk1, input int rk2, input int kern);
      csr_write(stsfu_pkg::REG_LEARN_RATE, lr);
      csr_write(stsfu_pkg::REG_REG_WEIGHT, lambda);
      csr_write(stsfu_pkg::REG_MODES, modes);
      csr_write(stsfu_pkg::REG_RANK_0, rk0);
      csr_write(stsfu_pkg::REG_RANK_1, rk1);
      csr_write(stsfu_pkg::REG_RANK_2, rk2);
      csr_write(stsfu_pkg::REG_KERNEL, kern);
   endtask

   task automatic random_item();
      int sel, m, value;
      sel = $urandom_range(0, 99);
      m = $urandom_range(0, stsfu_pkg::MODES - 1);
      value = ($urandom_range(0, 9) == 0) ? int'($urandom) : small_q16() * 2;
      if (sel < 35)
         send_item(stsfu_pkg::OP_TRAIN, $urandom, pick_row(0), pick_row(1), pick_row(2),
                   $urandom, $urandom, value);
      else if (sel < 55)
         send_item(stsfu_pkg::OP_PREDICT, $urandom, pick_row(0), pick_row(1), pick_row(2),
                   $urandom, $urandom, value);
      else if (sel < 65)
         send_item(stsfu_pkg::OP_READ_FACTOR, m, pick_row(m), $urandom, $urandom,
                   $urandom, $urandom, $urandom);
      else if (sel < 77)
         send_item(stsfu_pkg::OP_LOAD_FACTOR, m, pick_row(m), $urandom, $urandom,
                   $urandom, $urandom, small_q16() / 2);
      else if (sel < 85)
         send_item(stsfu_pkg::OP_LOAD_CORE, m, $urandom, $urandom, $urandom,
                   $urandom, $urandom, small_q16());
      else if (sel < 90)
         send_item(OP_UNUSED_FIRST + 3'($urandom_range(0, 2)), $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (sel < 95)
         send_item(3'($urandom_range(0, 1)) + (($urandom_range(0, 1) == 1) ?
                   stsfu_pkg::OP_READ_FACTOR : stsfu_pkg::OP_LOAD_FACTOR), MODE_NONE,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
         load_row(m, $urandom_range(0, stsfu_pkg::ROWS_PER_MODE - 1));
   endtask

   initial begin
      int r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int m = 0; m < stsfu_pkg::MODES; m++)
         for (int j = 0; j < stsfu_pkg::RANK_MAX; j++)
            for (int k = 0; k < stsfu_pkg::KERNEL_MAX; k++)
               send_item(stsfu_pkg::OP_LOAD_CORE, m, $urandom, $urandom, $urandom, j, k,
                         small_q16());
      for (int m = 0; m < stsfu_pkg::MODES; m++) begin
         load_row(m, 0);
         load_row(m, stsfu_pkg::ROWS_PER_MODE - 1);
         load_row(m, $urandom_range(1, stsfu_pkg::ROWS_PER_MODE - 2));
      end

      // Extreme values, every op, unknown codes and an unmapped mode.
      send_item(stsfu_pkg::OP_PREDICT, 0, 0, 0, 0, 0, 0, 32'sh7fffffff);
      send_item(stsfu_pkg::OP_PREDICT, 3, 1023, 1023, 1023, 7, 3, 32'sh80000000);
      send_item(stsfu_pkg::OP_TRAIN, 0, 0, 1023, 0, 0, 0, 32'sh7fffffff);
      send_item(stsfu_pkg::OP_TRAIN, 3, 1023, 0, 1023, 7, 3, 32'sh80000000);
      send_item(stsfu_pkg::OP_READ_FACTOR, 0, 0, 0, 0, 0, 0, 0);
      send_item(stsfu_pkg::OP_READ_FACTOR, 2, 1023, 1023, 1023, 7, 3, -1);
      send_item(stsfu_pkg::OP_LOAD_FACTOR, 1, 1023, 0, 0, 7, 3, 32'sh7fffffff);
      send_item(stsfu_pkg::OP_READ_FACTOR, 1, 1023, 0, 0, 7, 0, 0);
      send_item(stsfu_pkg::OP_LOAD_CORE, 2, 0, 0, 0, 7, 3, 32'sh7fffffff);
      send_item(stsfu_pkg::OP_PREDICT, 0, 0, 1023, 1023, 0, 0, 0);
      send_item(stsfu_pkg::OP_LOAD_FACTOR, 1, 1023, 0, 0, 7, 3, 32'sh80000000);
      send_item(stsfu_pkg::OP_TRAIN, 1, 1023, 1023, 0, 0, 0, 0);
      send_item(stsfu_pkg::OP_LOAD_FACTOR, MODE_NONE, 5, 0, 0, 2, 1, 1234);
      send_item(stsfu_pkg::OP_LOAD_CORE, MODE_NONE, 0, 0, 0, 2, 1, 1234);
      send_item(stsfu_pkg::OP_READ_FACTOR, MODE_NONE, 5, 0, 0, 2, 0, 0);
      for (int u = 0; u < 3; u++)
         send_item(OP_UNUSED_FIRST + 3'(u), u, 1023, 1023, 1023, 7, 3, -1);
      send_item(stsfu_pkg::OP_LOAD_FACTOR, 1, 1023, 0, 0, 7, 3, small_q16());
      send_item(stsfu_pkg::OP_LOAD_CORE, 2, 0, 0, 0, 7, 3, small_q16());

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0: configure(int'(stsfu_pkg::LEARN_RATE_RESET), int'(stsfu_pkg::REG_WEIGHT_RESET),
                         int'(stsfu_pkg::MODES_RESET), int'(stsfu_pkg::RANK_RESET),
                         int'(stsfu_pkg::RANK_RESET), int'(stsfu_pkg::RANK_RESET),
                         int'(stsfu_pkg::KERNEL_RESET));
            1: configure(32'h00ffffff, 0, 2, 1, 1, 1, 1);
            2: configure(0, 32'h00ffffff, 3, 8, 8, 8, 4);
            3: configure($urandom, $urandom, 0, 0, 15, 9, 7);
            4: configure($urandom_range(0, 200000), $urandom_range(0, 2000000), 1,
                         $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8), 0);
            default: begin
               idling = 1'b0;
               configure($urandom_range(0, 100000), $urandom_range(0, 1000000),
                         $urandom_range(2, 3), $urandom_range(1, 8), $urandom_range(1, 8),
                         $urandom_range(1, 8), $urandom_range(1, 4));
            end
         endcase
         r = 0;
         while (r < 30) begin
            random_item();
            r++;
         end
      end

      wait_drained();
      if (failures == 0)
         $display("tb_sparse_tucker_sgd_factor_update_unit passed");
      else
         $display("tb_sparse_tucker_sgd_factor_update_unit failed");
      $finish;
   end
endmodule
